// ===== sv/hsv_pkg.sv =====
// HSV to RGB converter: shared constants, selection codes and stage payload types.
// No dependencies; imported by every module of the converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

  localparam int unsigned HueFull    = 5760;   // 360 degrees in 1/16 degree
  localparam int unsigned HueSector  = 960;    // 60 degrees in 1/16 degree
  localparam int unsigned HueBias    = 34560;  // 6 * HueFull, makes the hue positive
  localparam int unsigned UnitOne    = 256;    // 1.0 with 8 fraction bits
  localparam int unsigned LevelMax   = 255;

  // floor(x / 5760) by reciprocal: may come out one low, fixed by one compare
  localparam int unsigned WrapRecip  = 93206;  // floor(2^29 / 5760)
  localparam int unsigned WrapShift  = 29;

  // floor(y / 15) for y < 90 by reciprocal, exact over that range
  localparam int unsigned SectRecip  = 137;
  localparam int unsigned SectShift  = 11;

  // 255 * N / (65536 * 960) == 17 * N / 2^22
  localparam int unsigned LevelMul   = 17;
  localparam int unsigned LevelShift = 22;

  // Hue sectors, named by which channel takes chroma and which the ramp
  localparam logic [2:0] SecRedGreen  = 3'd0;
  localparam logic [2:0] SecGreenRed  = 3'd1;
  localparam logic [2:0] SecGreenBlue = 3'd2;
  localparam logic [2:0] SecBlueGreen = 3'd3;
  localparam logic [2:0] SecBlueRed   = 3'd4;
  localparam logic [2:0] SecRedBlue   = 3'd5;

  typedef logic [9:0] tnum_t;

  typedef struct packed {
    logic [12:0] hue_pos;
    logic [8:0]  sat;
    logic [8:0]  bri;
    logic [17:0] mbase;
  } wrap_out_t;

  typedef struct packed {
    tnum_t [2:0] t_num;
    logic [8:0]  sat;
    logic [8:0]  bri;
    logic [17:0] mbase;
  } chan_in_t;

endpackage

`default_nettype wire

// ===== sv/hsv_hue_wrap.sv =====
// HSV to RGB converter, stages 1 and 2: clamp s and v, wrap hue into [0, 5760),
// form the floor term 960 * (256 - s). Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_hue_wrap
  import hsv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] hue_i,
  input  wire logic        [8:0]  saturation_i,
  input  wire logic        [8:0]  brightness_i,
  output      logic               valid_o,
  output      wrap_out_t          data_o
);

  logic [17:0] hue_sx;
  logic [17:0] biased;
  logic [33:0] wrap_prod;
  logic [8:0]  sat_d, bri_d;
  logic [3:0]  quo_d;

  logic        v1_q;
  logic [16:0] x_q;
  logic [3:0]  quo_q;
  logic [8:0]  sat1_q, bri1_q;

  logic [16:0] hp_raw;
  logic [12:0] hp_d;
  logic [8:0]  inv_s;
  logic [17:0] mbase_d;

  logic        v2_q;
  wrap_out_t   out_q;

  always_comb begin
    hue_sx    = {{2{hue_i[15]}}, hue_i};
    biased    = hue_sx + 18'(HueBias);
    wrap_prod = 34'(biased[16:0]) * 34'(WrapRecip);
    quo_d     = wrap_prod[WrapShift+3:WrapShift];
    sat_d     = (saturation_i > 9'(UnitOne)) ? 9'(UnitOne) : saturation_i;
    bri_d     = (brightness_i > 9'(UnitOne)) ? 9'(UnitOne) : brightness_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q    <= biased[16:0];
      quo_q  <= quo_d;
      sat1_q <= sat_d;
      bri1_q <= bri_d;
    end
  end

  always_comb begin
    hp_raw  = x_q - 17'(quo_q * 17'(HueFull));
    hp_d    = (hp_raw >= 17'(HueFull)) ? 13'(hp_raw - 17'(HueFull)) : hp_raw[12:0];
    inv_s   = 9'(10'(UnitOne) - {1'b0, sat1_q});
    mbase_d = 18'(18'(inv_s) * 18'(HueSector));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.hue_pos <= hp_d;
      out_q.sat     <= sat1_q;
      out_q.bri     <= bri1_q;
      out_q.mbase   <= mbase_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/hsv_sector.sv =====
// HSV to RGB converter, stages 3 and 4: split the wrapped hue into sector and
// offset, build the ramp numerator and route c / x / 0 per channel. Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_sector
  import hsv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      valid_i,
  input  wire wrap_out_t data_i,
  output      logic      valid_o,
  output      chan_in_t  data_o
);

  logic [14:0] sect_prod;
  logic [2:0]  sect_d;

  logic        v3_q;
  logic [2:0]  sect_q;
  wrap_out_t   s3_q;

  logic [12:0] r_full;
  tnum_t       r_off;
  tnum_t       fnum;
  tnum_t       full_t;
  tnum_t [2:0] tn_d;

  logic        v4_q;
  chan_in_t    out_q;

  always_comb begin
    sect_prod = 15'(data_i.hue_pos[12:6]) * 15'(SectRecip);
    sect_d    = sect_prod[SectShift+2:SectShift];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sect_q <= sect_d;
      s3_q   <= data_i;
    end
  end

  // tn_d index: 2 = red, 1 = green, 0 = blue
  always_comb begin
    r_full = s3_q.hue_pos - 13'(sect_q * 13'(HueSector));
    r_off  = r_full[9:0];
    full_t = tnum_t'(HueSector);
    fnum   = sect_q[0] ? (full_t - r_off) : r_off;
    case (sect_q)
      SecRedGreen:  tn_d = {full_t, fnum,   10'd0};
      SecGreenRed:  tn_d = {fnum,   full_t, 10'd0};
      SecGreenBlue: tn_d = {10'd0,  full_t, fnum};
      SecBlueGreen: tn_d = {10'd0,  fnum,   full_t};
      SecBlueRed:   tn_d = {fnum,   10'd0,  full_t};
      default:      tn_d = {full_t, 10'd0,  fnum};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.t_num <= tn_d;
      out_q.sat   <= s3_q.sat;
      out_q.bri   <= s3_q.bri;
      out_q.mbase <= s3_q.mbase;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/hsv_channel.sv =====
// HSV to RGB converter, stages 5 to 7 of one color channel:
// level = floor(17 * v * (s * t + 960 * (256 - s)) / 2^22). Depends on hsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv_channel
  import hsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        adv_i,
  input  wire tnum_t       t_num_i,
  input  wire logic [8:0]  sat_i,
  input  wire logic [8:0]  bri_i,
  input  wire logic [17:0] mbase_i,
  output      logic [7:0]  level_o
);

  logic [18:0] mix;
  logic [17:0] a_q;
  logic [8:0]  bri_q;
  logic [26:0] num;
  logic [25:0] num_q;
  logic [30:0] scaled;
  logic [8:0]  lvl_raw;
  logic [7:0]  level_q;

  always_comb begin
    mix     = (19'(sat_i) * 19'(t_num_i)) + 19'(mbase_i);
    num     = 27'(bri_q) * 27'(a_q);
    scaled  = 31'(num_q) * 31'(LevelMul);
    lvl_raw = scaled[LevelShift+8:LevelShift];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q     <= mix[17:0];
      bri_q   <= bri_i;
      num_q   <= num[25:0];
      level_q <= (lvl_raw > 9'(LevelMax)) ? 8'(LevelMax) : lvl_raw[7:0];
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level: hue wrap, sector split and three channel pipes.
// Depends on hsv_pkg, hsv_hue_wrap, hsv_sector and hsv_channel.
//
// Input channel: in_valid_i / in_stall_o with hue_i (signed, 1/16 degree),
// saturation_i and brightness_i (8 fraction bits, values above 256 read as 1.0).
// Output channel: out_valid_o / out_stall_i with red_level_o, green_level_o,
// blue_level_o. A transfer happens on a rising edge with valid high and stall low.
//
// Seven register stages: a result shows on the outputs once it reaches the last stage
// and transfers out on an edge where out_stall_i is low.
// One transfer per cycle is sustained while the output is not stalled; each stage holds one pixel.
// The whole pipe advances together: while the output holds an unaccepted
// result and out_stall_i is high, every stage holds and in_stall_o is high.
// Bubbles move forward whenever the output is empty or being taken.
// Reset clears all stage valid bits; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] hue_i,
  input  wire logic        [8:0]  saturation_i,
  input  wire logic        [8:0]  brightness_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic        [7:0]  red_level_o,
  output      logic        [7:0]  green_level_o,
  output      logic        [7:0]  blue_level_o
);

  logic      adv;
  logic      wrap_valid, sect_valid;
  wrap_out_t wrap_data;
  chan_in_t  sect_data;
  logic      v5_q, v6_q, v7_q;

  assign adv        = !(v7_q && out_stall_i);
  assign in_stall_o = !adv;

  hsv_hue_wrap u_wrap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (wrap_valid),
    .data_o       (wrap_data)
  );

  hsv_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (wrap_valid),
    .data_i  (wrap_data),
    .valid_o (sect_valid),
    .data_o  (sect_data)
  );

  hsv_channel u_red (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .t_num_i (sect_data.t_num[2]),
    .sat_i   (sect_data.sat),
    .bri_i   (sect_data.bri),
    .mbase_i (sect_data.mbase),
    .level_o (red_level_o)
  );

  hsv_channel u_green (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .t_num_i (sect_data.t_num[1]),
    .sat_i   (sect_data.sat),
    .bri_i   (sect_data.bri),
    .mbase_i (sect_data.mbase),
    .level_o (green_level_o)
  );

  hsv_channel u_blue (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .t_num_i (sect_data.t_num[0]),
    .sat_i   (sect_data.sat),
    .bri_i   (sect_data.bri),
    .mbase_i (sect_data.mbase),
    .level_o (blue_level_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v5_q <= sect_valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  assign out_valid_o = v7_q;

endmodule

`default_nettype wire
